// ===== rtl/core/literal_text_search_word_bounds_top_defines.svh =====
// Assertion macros shared by the word-bounded text search block.
// Included by the modules that check their own control logic; needs no package.
`ifndef LITERAL_TEXT_SEARCH_WORD_BOUNDS_TOP_DEFINES_SVH
`define LITERAL_TEXT_SEARCH_WORD_BOUNDS_TOP_DEFINES_SVH
`ifndef SYNTH
// Expression holds at every clock edge outside reset.
`define LTSWB_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define LTSWB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define LTSWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LTSWB_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define LTSWB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LTSWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ltswb_pkg.sv =====
// Shared types, codes and character helpers of the word-bounded text search block.
// No dependencies; imported by every module of the block.
package ltswb_pkg;

    localparam int NEEDLE_W = 64;
    localparam int START_W  = 24;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int LEN_REG_W = 5;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NEEDLE_LOW     = 3'd0;
    localparam t_cfg_idx CFG_NEEDLE_HIGH    = 3'd1;
    localparam t_cfg_idx CFG_NEEDLE_LENGTH  = 3'd2;
    localparam t_cfg_idx CFG_MATCH_MODE     = 3'd3;
    localparam t_cfg_idx CFG_CASE_SENSITIVE = 3'd4;

    typedef enum logic [1:0] {
        MODE_CONTAINS    = 2'd0,
        MODE_WHOLE_WORD  = 2'd1,
        MODE_STARTS_WITH = 2'd2,
        MODE_ENDS_WITH   = 2'd3
    } t_mode;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKQUOTE  = 8'h60;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Control part of one queue entry: up to two results caused by one item.
    typedef struct packed {
        logic a_vld;    // resolved pending hit, always found
        logic b_vld;    // end-of-text result: new hit or empty marker
        logic b_found;
        logic last;     // entry closes the text
        logic ovf;
    } t_evt_ctl;

    function automatic logic is_word(input logic [7:0] c);
        logic res;
        case (c) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_UNDERSCORE, CH_BACKQUOTE:
                res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] res;
        case (c) inside
            [8'h41:8'h5A]: res = c + CASE_OFFSET;
            default:       res = c;
        endcase
        return res;
    endfunction

    function automatic logic hit_accept(input t_mode mode, input logic before_ok,
                                        input logic after_ok);
        logic res;
        case (mode)
            MODE_WHOLE_WORD:  res = before_ok & after_ok;
            MODE_STARTS_WITH: res = before_ok;
            MODE_ENDS_WITH:   res = after_ok;
            default:          res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/literal_text_search_word_bounds_top.sv =====
// Top level of the whole-word literal text search block.
// Depends on ltswb_pkg, ltswb_front, ltswb_queue and ltswb_back.
//
// Text enters one character per item on the push/full side; an item is taken
// at a clock edge with push high and full low. Results leave on the empty/pop
// side: the oldest result sits on the o_ ports while empty is low and is taken
// at an edge with pop high. The user writes registers via i_cfg_we, i_cfg_idx
// and i_cfg_wdata only while no text is in flight; the block does no check.
// The front takes one character every cycle while full is low, comparing a
// full needle window in parallel; its results enter a four-entry queue at the
// same edge, then reach the outputs. A hit is known one character after its
// end (the after-boundary needs that character) or at the end of the text.
// The last result of a text has text_done set; a text without accepted hits
// yields one result with match_found low.
// Only the final character of a text can cause two results; the back side
// hands them out in turn while the queue absorbs the extra one, so a
// receiver that pops every cycle never stalls the input.
// When the receiver stalls the queue fills and full rises after four waiting
// entries. Reset clears the queue and the text state and restores register
// defaults.
module literal_text_search_word_bounds_top #(
    parameter int MAX_NEEDLE = 16,
    parameter int POS_BITS   = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_text_char,
    input  logic                              i_text_last,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_match_found,
    output logic [ltswb_pkg::START_W-1:0]     o_match_start,
    output logic                              o_text_done,
    output logic                              o_position_overflow,
    input  logic                              i_cfg_we,
    input  ltswb_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [ltswb_pkg::NEEDLE_W-1:0]    i_cfg_wdata
);
    import ltswb_pkg::*;

    logic                accept;
    logic                q_push;
    t_evt_ctl            f_ctl;
    logic [POS_BITS-1:0] f_a_start;
    logic [POS_BITS-1:0] f_b_start;
    logic                q_empty;
    t_evt_ctl            q_ctl;
    logic [POS_BITS-1:0] q_a_start;
    logic [POS_BITS-1:0] q_b_start;
    logic                q_deq;

    assign accept = push & ~full;

    ltswb_front #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .POS_BITS   (POS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_char (i_text_char),
        .i_text_last (i_text_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (q_push),
        .o_ctl       (f_ctl),
        .o_a_start   (f_a_start),
        .o_b_start   (f_b_start)
    );

    ltswb_queue #(
        .POS_BITS (POS_BITS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_ctl     (f_ctl),
        .i_a_start (f_a_start),
        .i_b_start (f_b_start),
        .i_pop     (q_deq),
        .o_full    (full),
        .o_empty   (q_empty),
        .o_ctl     (q_ctl),
        .o_a_start (q_a_start),
        .o_b_start (q_b_start)
    );

    ltswb_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (q_empty),
        .i_ctl               (q_ctl),
        .i_a_start           (q_a_start),
        .i_b_start           (q_b_start),
        .i_pop               (pop),
        .o_deq               (q_deq),
        .o_empty             (empty),
        .o_match_found       (o_match_found),
        .o_match_start       (o_match_start),
        .o_text_done         (o_text_done),
        .o_position_overflow (o_position_overflow)
    );

endmodule

// ===== rtl/core/ltswb_front.sv =====
// Front part: configuration registers, character history, window compare and
// hit filtering. Depends on ltswb_pkg; feeds entries into ltswb_queue.
module ltswb_front #(
    parameter int MAX_NEEDLE = 16,
    parameter int POS_BITS   = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [7:0]                         i_text_char,
    input  logic                               i_text_last,
    input  logic                               i_cfg_we,
    input  ltswb_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [ltswb_pkg::NEEDLE_W-1:0]     i_cfg_wdata,
    output logic                               o_push,
    output ltswb_pkg::t_evt_ctl                o_ctl,
    output logic [POS_BITS-1:0]                o_a_start,
    output logic [POS_BITS-1:0]                o_b_start
);
    import ltswb_pkg::*;

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int HIST  = MAX_NEEDLE + 1;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [NEEDLE_W-1:0]  r_needle_low;
    logic [NEEDLE_W-1:0]  r_needle_high;
    logic [LEN_REG_W-1:0] r_len;
    t_mode                r_mode;
    logic                 r_case;

    logic [7:0]          r_hist [MAX_NEEDLE];
    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] r_next;
    logic                r_pend_vld;
    logic [POS_BITS-1:0] r_pend_start;
    logic                r_pend_bok;
    logic                r_ovf;

    logic [7:0]          win [HIST];
    logic [7:0]          win_f [HIST];
    logic [7:0]          ndl_f [MAX_NEEDLE];
    logic [LEN_W-1:0]    n_len;
    logic [POS_BITS:0]   cur1;
    logic [POS_BITS:0]   len_ext;
    logic [POS_BITS:0]   s_full;
    logic [POS_BITS-1:0] s_pos;
    logic [POS_BITS-1:0] n_pos;
    logic                sat;
    logic                ovf_now;
    logic                all_eq;
    logic                hit;
    logic                before_ok;
    logic                after_ok;
    logic                a_vld;
    logic                new_acc;

    always_comb begin
        logic [2*NEEDLE_W-1:0] ndl;
        ndl = {r_needle_high, r_needle_low};
        win[0] = i_text_char;
        for (int k = 1; k < HIST; k++) begin
            win[k] = r_hist[k-1];
        end
        for (int k = 0; k < HIST; k++) begin
            win_f[k] = r_case ? win[k] : to_lower(win[k]);
        end
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            ndl_f[j] = r_case ? ndl[8*j +: 8] : to_lower(ndl[8*j +: 8]);
        end
    end

    assign n_len = (r_len > LEN_REG_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : LEN_W'(r_len);

    assign sat     = (r_pos == POS_MAX);
    assign ovf_now = r_ovf | sat;
    assign n_pos   = sat ? r_pos : r_pos + POS_BITS'(1);
    assign cur1    = {1'b0, r_pos} + (POS_BITS+1)'(1);
    assign len_ext = (POS_BITS+1)'(n_len);
    assign s_full  = cur1 - len_ext;
    assign s_pos   = s_full[POS_BITS-1:0];

    // Needle character j lines up with the window slot n-1-j.
    always_comb begin
        logic [LEN_W-1:0] idx;
        all_eq = 1'b1;
        idx    = '0;
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            idx = n_len - LEN_W'(j) - LEN_W'(1);
            if ((LEN_W'(j) < n_len) && (win_f[idx] != ndl_f[j])) begin
                all_eq = 1'b0;
            end
        end
    end

    assign hit       = (n_len != '0) && (cur1 >= len_ext) && (s_pos >= r_next) && all_eq;
    assign before_ok = (s_pos == '0) || !is_word(win[n_len]);
    assign after_ok  = !is_word(i_text_char) && (i_text_char != CH_BANG);
    assign a_vld     = r_pend_vld & hit_accept(r_mode, r_pend_bok, after_ok);
    assign new_acc   = hit & hit_accept(r_mode, before_ok, 1'b1);

    always_comb begin
        o_ctl.a_vld   = a_vld;
        o_ctl.b_vld   = i_text_last & (new_acc | ~a_vld);
        o_ctl.b_found = new_acc;
        o_ctl.last    = i_text_last;
        o_ctl.ovf     = ovf_now;
        o_a_start     = r_pend_start;
        o_b_start     = new_acc ? s_pos : '0;
        o_push        = i_accept & (o_ctl.a_vld | o_ctl.b_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_len         <= '0;
            r_mode        <= MODE_CONTAINS;
            r_case        <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NEEDLE_LOW:     r_needle_low  <= i_cfg_wdata;
                CFG_NEEDLE_HIGH:    r_needle_high <= i_cfg_wdata;
                CFG_NEEDLE_LENGTH:  r_len         <= i_cfg_wdata[LEN_REG_W-1:0];
                CFG_MATCH_MODE:     r_mode        <= t_mode'(i_cfg_wdata[1:0]);
                CFG_CASE_SENSITIVE: r_case        <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_next     <= '0;
            r_pend_vld <= 1'b0;
            r_pend_bok <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (i_accept) begin
            if (i_text_last) begin
                r_pos      <= '0;
                r_next     <= '0;
                r_pend_vld <= 1'b0;
                r_pend_bok <= 1'b0;
                r_ovf      <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_ovf      <= ovf_now;
                r_pend_vld <= hit;
                if (hit) begin
                    // The hit ends at the current character, so the next start
                    // may be no earlier than the following offset.
                    r_next     <= n_pos;
                    r_pend_bok <= before_ok;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hist[0] <= i_text_char;
            for (int k = 1; k < MAX_NEEDLE; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            if (hit) begin
                r_pend_start <= s_pos;
            end
        end
    end

endmodule

// ===== rtl/core/ltswb_queue.sv =====
// Short queue of result entries between the front and back parts.
// Depends on ltswb_pkg and the assertion macro header.
`include "literal_text_search_word_bounds_top_defines.svh"
module ltswb_queue #(
    parameter int POS_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ltswb_pkg::t_evt_ctl i_ctl,
    input  logic [POS_BITS-1:0] i_a_start,
    input  logic [POS_BITS-1:0] i_b_start,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ltswb_pkg::t_evt_ctl o_ctl,
    output logic [POS_BITS-1:0] o_a_start,
    output logic [POS_BITS-1:0] o_b_start
);
    import ltswb_pkg::*;

    t_evt_ctl            r_ctl   [QDEPTH];
    logic [POS_BITS-1:0] r_a     [QDEPTH];
    logic [POS_BITS-1:0] r_b     [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign o_full    = (r_count == QCNT_W'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign do_pop    = i_pop & ~o_empty;
    assign o_ctl     = r_ctl[r_rptr];
    assign o_a_start = r_a[r_rptr];
    assign o_b_start = r_b[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wptr] <= i_ctl;
            r_a[r_wptr]   <= i_a_start;
            r_b[r_wptr]   <= i_b_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `LTSWB_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH))
    `LTSWB_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `LTSWB_ASSERT_SAME(a_entry_has_result, i_clk, i_rst_n, i_push, i_ctl.a_vld || i_ctl.b_vld)

endmodule

// ===== rtl/core/ltswb_back.sv =====
// Back part: walks each queue entry and presents its results one item at a time.
// Depends on ltswb_pkg and the assertion macro header; reads ltswb_queue's head.
`include "literal_text_search_word_bounds_top_defines.svh"
module ltswb_back #(
    parameter int POS_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  ltswb_pkg::t_evt_ctl               i_ctl,
    input  logic [POS_BITS-1:0]               i_a_start,
    input  logic [POS_BITS-1:0]               i_b_start,
    input  logic                              i_pop,
    output logic                              o_deq,
    output logic                              o_empty,
    output logic                              o_match_found,
    output logic [ltswb_pkg::START_W-1:0]     o_match_start,
    output logic                              o_text_done,
    output logic                              o_position_overflow
);
    import ltswb_pkg::*;

    logic r_sub;
    logic at_a;
    logic take;

    // The first slot is shown only while it holds a hit and has not gone yet.
    assign at_a    = i_ctl.a_vld & ~r_sub;
    assign take    = i_pop & ~i_empty;
    assign o_deq   = take & ~(at_a & i_ctl.b_vld);
    assign o_empty = i_empty;

    always_comb begin
        o_match_found       = at_a ? 1'b1 : i_ctl.b_found;
        o_match_start       = at_a ? START_W'(i_a_start) : START_W'(i_b_start);
        o_text_done         = at_a ? (i_ctl.last & ~i_ctl.b_vld) : i_ctl.last;
        o_position_overflow = i_ctl.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (take) begin
            r_sub <= at_a & i_ctl.b_vld;
        end
    end

    `LTSWB_ASSERT_SAME(a_sub_on_pair, i_clk, i_rst_n, r_sub,
        !i_empty && i_ctl.a_vld && i_ctl.b_vld)
    `LTSWB_ASSERT_NEXT(a_done_ends_entry, i_clk, i_rst_n, take && o_text_done, !r_sub)
    `LTSWB_ASSERT_SAME(a_empty_marker, i_clk, i_rst_n, !i_empty && !o_match_found,
        o_text_done && (o_match_start == '0))

endmodule

// ===== tb/literal_text_search_word_bounds_top_tb.sv =====
// Self-checking testbench for the whole-word literal text search block.
// Depends on ltswb_pkg and literal_text_search_word_bounds_top; predicts the match
// reports of every text and checks each popped result against them.
module literal_text_search_word_bounds_top_tb;
    import ltswb_pkg::*;

    localparam int          RANDOM_CHARS = 950;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          HIST_LEN     = 17;
    localparam int unsigned POS_LIMIT    = (32'd1 << START_W) - 1;

    typedef struct {
        bit               found;
        logic [START_W-1:0] start;
        bit               done;
        bit               ovf;
    } t_match_rec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [7:0]            i_text_char;
    logic                  i_text_last;
    logic                  empty;
    logic                  pop;
    logic                  o_match_found;
    logic [START_W-1:0]    o_match_start;
    logic                  o_text_done;
    logic                  o_position_overflow;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [NEEDLE_W-1:0]   i_cfg_wdata;

    // Register copies used by the predictor.
    logic [63:0] ndl_lo    = '0;
    logic [63:0] ndl_hi    = '0;
    logic [4:0]  ndl_len   = '0;
    t_mode       srch_mode = MODE_CONTAINS;
    bit          exact     = 1'b1;

    // Per-text scan state.
    logic [7:0]  hist [HIST_LEN];
    int unsigned text_pos;
    int unsigned next_start;
    bit          hold_valid;
    int unsigned hold_start;
    bit          hold_before;
    bit          pos_ovf;

    t_match_rec  awaited_matches[$];
    int          errors     = 0;
    int          chars_sent = 0;
    int          cycles     = 0;
    bit          no_stalls  = 1'b0;

    literal_text_search_word_bounds_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_text_char         (i_text_char),
        .i_text_last         (i_text_last),
        .empty               (empty),
        .pop                 (pop),
        .o_match_found       (o_match_found),
        .o_match_start       (o_match_start),
        .o_text_done         (o_text_done),
        .o_position_overflow (o_position_overflow),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit word_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_UNDERSCORE || c == CH_BACKQUOTE;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c | 8'h20 : c;
    endfunction

    function automatic logic [7:0] needle_byte(input int j);
        return (j < 8) ? ndl_lo[8*j +: 8] : ndl_hi[8*(j-8) +: 8];
    endfunction

    function automatic bit mode_accepts(input bit before_ok, input bit after_ok);
        case (srch_mode)
            MODE_WHOLE_WORD:  return before_ok && after_ok;
            MODE_STARTS_WITH: return before_ok;
            MODE_ENDS_WITH:   return after_ok;
            default:          return 1'b1;
        endcase
    endfunction

    function automatic void clear_text_state();
        for (int i = 0; i < HIST_LEN; i++) hist[i] = '0;
        text_pos    = 0;
        next_start  = 0;
        hold_valid  = 1'b0;
        hold_start  = 0;
        hold_before = 1'b0;
        pos_ovf     = 1'b0;
    endfunction

    // Advances the scan by one character and queues the match reports it causes.
    function automatic void scan_char(input logic [7:0] c, input bit last);
        t_match_rec  res [2];
        int          cnt;
        int unsigned cur, s, n;
        bit          hit;
        logic [7:0]  a, b;
        cnt = 0;
        cur = text_pos;
        if (cur >= POS_LIMIT) begin
            cur     = POS_LIMIT;
            pos_ovf = 1'b1;
        end
        for (int i = HIST_LEN - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = c;

        // A held hit learns its after-boundary from this character.
        if (hold_valid) begin
            if (mode_accepts(hold_before, !word_ch(c) && c != CH_BANG)) begin
                res[cnt] = '{1'b1, hold_start[START_W-1:0], 1'b0, pos_ovf};
                cnt++;
            end
            hold_valid = 1'b0;
        end

        n = (ndl_len > 16) ? 16 : ndl_len;
        if (n > 0 && cur + 1 >= n) begin
            s = cur + 1 - n;
            if (s >= next_start) begin
                hit = 1'b1;
                for (int j = 0; j < n; j++) begin
                    a = hist[n-1-j];
                    b = needle_byte(j);
                    if (!exact) begin
                        a = fold(a);
                        b = fold(b);
                    end
                    if (a != b) hit = 1'b0;
                end
                if (hit) begin
                    hold_valid  = 1'b1;
                    hold_start  = s;
                    hold_before = (s == 0) || !word_ch(hist[n]);
                    next_start  = (s + n > POS_LIMIT) ? POS_LIMIT : s + n;
                end
            end
        end

        if (last) begin
            if (hold_valid && mode_accepts(hold_before, 1'b1)) begin
                res[cnt] = '{1'b1, hold_start[START_W-1:0], 1'b0, pos_ovf};
                cnt++;
            end
            if (cnt == 0) begin
                res[cnt] = '{1'b0, '0, 1'b0, pos_ovf};
                cnt++;
            end
            res[cnt-1].done = 1'b1;
            clear_text_state();
        end else begin
            text_pos = (cur < POS_LIMIT) ? cur + 1 : POS_LIMIT;
        end
        for (int i = 0; i < cnt; i++) awaited_matches.insert(awaited_matches.size(), res[i]);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_alpha();
        string alpha;
        alpha = "aAbB_`!0 .";
        return alpha[$urandom_range(0, 9)];
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 7))
            0:       return " ";
            1:       return CH_BANG;
            2:       return ".";
            3:       return CH_UNDERSCORE;
            4:       return CH_BACKQUOTE;
            5:       return 8'h80 | 8'($urandom_range(0, 127));
            6:       return "9";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [127:0] pack_needle(input string s);
        logic [127:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 16; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit last);
        int gap;
        @(negedge i_clk);
        push        <= 1'b1;
        i_text_char <= c;
        i_text_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        scan_char(c, last);
        chars_sent++;
        gap = no_stalls ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push        <= 1'b0;
            i_text_char <= 8'($urandom);
            i_text_last <= 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (awaited_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
    endtask

    // Registers change only once every report of the previous text is out.
    task automatic set_search(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input t_mode mode, input bit cs);
        wait_drained();
        write_reg(CFG_NEEDLE_LOW, lo);
        write_reg(CFG_NEEDLE_HIGH, hi);
        write_reg(CFG_NEEDLE_LENGTH, {59'd0, len});
        write_reg(CFG_MATCH_MODE, {62'd0, mode});
        write_reg(CFG_CASE_SENSITIVE, {63'd0, cs});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ndl_lo    = lo;
        ndl_hi    = hi;
        ndl_len   = len;
        srch_mode = mode;
        exact     = cs;
    endtask

    task automatic test_empty_needle();
        // Reset values first, then all-ones needle bytes with zero length.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        set_search('1, '1, 5'd0, MODE_ENDS_WITH, 1'b0);
        send_char("a", 1'b1);
    endtask

    task automatic test_contains();
        // Greedy scan: the overlapping hit at offset 1 is skipped.
        set_search(pack_needle("aa"), '0, 5'd2, MODE_CONTAINS, 1'b1);
        send_text("aaaa");
        // Last character both resolves a held hit and finds a new one.
        set_search(pack_needle("a"), '0, 5'd1, MODE_CONTAINS, 1'b1);
        send_text("aa");
    endtask

    task automatic test_word_modes();
        logic [127:0] ndl;
        ndl = pack_needle("ab");
        set_search(ndl[63:0], ndl[127:64], 5'd2, MODE_WHOLE_WORD, 1'b1);
        send_text("ab!ab");
        set_search(ndl[63:0], ndl[127:64], 5'd2, MODE_STARTS_WITH, 1'b1);
        send_text("ab!ab");
        set_search(ndl[63:0], ndl[127:64], 5'd2, MODE_ENDS_WITH, 1'b1);
        send_text("`ab");
    endtask

    task automatic test_case_fold();
        logic [127:0] ndl;
        ndl = pack_needle("Ab");
        set_search(ndl[63:0], ndl[127:64], 5'd2, MODE_CONTAINS, 1'b0);
        send_text("aB");
    endtask

    // Texts built mostly from needle copies, prefixes and separators.
    task automatic test_random_texts();
        logic [127:0] ndl;
        logic [7:0]   text[$];
        logic [7:0]   c;
        logic [4:0]   len;
        int           stop_at, n_eff, target, pick, phase, cut;
        stop_at = chars_sent + RANDOM_CHARS;
        phase   = 0;
        while (chars_sent < stop_at) begin
            ndl = {$urandom, $urandom, $urandom, $urandom};
            for (int k = 0; k < 16; k++)
                if ($urandom_range(0, 9) < 8) ndl[8*k +: 8] = pick_alpha();
            pick = $urandom_range(0, 99);
            if (phase == 0)      len = 5'd31;
            else if (phase == 1) len = 5'd16;
            else if (pick < 5)   len = 5'd0;
            else if (pick < 15)  len = 5'($urandom_range(17, 31));
            else if (pick < 30)  len = 5'($urandom_range(9, 16));
            else                 len = 5'($urandom_range(1, 4));
            set_search(ndl[63:0], ndl[127:64], len, t_mode'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)));
            no_stalls = ($urandom_range(0, 4) == 0);
            n_eff = (len > 16) ? 16 : len;
            repeat ($urandom_range(2, 6)) begin
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 20);
                text.delete();
                while (text.size() < target) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40 && n_eff > 0) begin
                        cut = (pick < 10 && n_eff > 1) ? $urandom_range(1, n_eff - 1) : n_eff;
                        for (int k = 0; k < cut; k++) begin
                            c = ndl[8*k +: 8];
                            // Flip letter case now and then to exercise folding.
                            if (fold(c) >= "a" && fold(c) <= "z" && $urandom_range(0, 3) == 0)
                                c = c ^ 8'h20;
                            text.insert(text.size(), c);
                        end
                    end else if (pick < 70) begin
                        text.insert(text.size(), pick_separator());
                    end else if (pick < 90) begin
                        text.insert(text.size(), pick_alpha());
                    end else begin
                        text.insert(text.size(), 8'($urandom));
                    end
                end
                for (int k = 0; k < text.size(); k++)
                    send_char(text[k], k == text.size() - 1);
            end
            phase++;
        end
        no_stalls = 1'b0;
    endtask

    task automatic check_match();
        t_match_rec want;
        if (awaited_matches.size() == 0) begin
            $display("%0t: result with none expected: found %0d start %0d done %0d",
                     $time, o_match_found, o_match_start, o_text_done);
            errors++;
        end else begin
            want = awaited_matches.pop_front();
            if (o_match_found !== want.found) begin
                $display("%0t: match_found expected %0d actual %0d",
                         $time, want.found, o_match_found);
                errors++;
            end
            if (o_match_start !== want.start) begin
                $display("%0t: match_start expected %0d actual %0d",
                         $time, want.start, o_match_start);
                errors++;
            end
            if (o_text_done !== want.done) begin
                $display("%0t: text_done expected %0d actual %0d",
                         $time, want.done, o_text_done);
                errors++;
            end
            if (o_position_overflow !== want.ovf) begin
                $display("%0t: position_overflow expected %0d actual %0d",
                         $time, want.ovf, o_position_overflow);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_match();
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("literal_text_search_word_bounds_top verification failed");
            $finish;
        end
    end

    // Result side: pops with random stalls; no new stall starts in a quiet stretch.
    initial begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if (!no_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_text_char = '0;
        i_text_last = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_NEEDLE_LOW;
        i_cfg_wdata = '0;
        clear_text_state();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_needle();
        test_contains();
        test_word_modes();
        test_case_fold();
        test_random_texts();

        wait_drained();
        if (errors == 0) begin
            $display("literal_text_search_word_bounds_top verification clean");
        end else begin
            $display("literal_text_search_word_bounds_top verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ltswb_pkg.sv
rtl/core/ltswb_front.sv
rtl/core/ltswb_queue.sv
rtl/core/ltswb_back.sv
rtl/core/literal_text_search_word_bounds_top.sv
tb/literal_text_search_word_bounds_top_tb.sv
